### design/mbrh_pkg.sv
// shared types and constants of the modbus read-holding-registers master
package mbrh_pkg;

	localparam int unsigned MAX_REGS_DEF = 16;

	localparam logic [15:0] TIMEOUT_RST = 16'd800;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  FUNC_READ   = 8'h03;

	// register index, taken from paddr[2]
	localparam logic REG_TIMEOUT = 1'b0;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_TX   = 2'd0,
		KIND_VAL  = 2'd1,
		KIND_OK   = 2'd2,
		KIND_FAIL = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		FAIL_NONE    = 3'd0,
		FAIL_TIMEOUT = 3'd1,
		FAIL_HEADER  = 3'd2,
		FAIL_CRC     = 3'd3,
		FAIL_COUNT   = 3'd4
	} fail_t;

	typedef struct packed {
		logic       init;
		logic       feed;
		logic [7:0] din;
	} crc_ctrl_t;

endpackage

### design/mbrh_crc.sv
// bit-serial crc-16/modbus, one bit per cycle after a byte is xored in
module mbrh_crc import mbrh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  crc_ctrl_t   ctrl,
	output logic [15:0] crc,
	output logic        busy
);

	localparam logic [3:0] BYTE_BITS = 4'd8;

	logic [15:0] crc_q;
	logic [3:0]  bit_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			bit_cnt_q <= 4'd0;
		end else if (ctrl.init) begin
			crc_q     <= CRC_INIT;
			bit_cnt_q <= 4'd0;
		end else if (ctrl.feed) begin
			crc_q     <= crc_q ^ {8'h00, ctrl.din};
			bit_cnt_q <= BYTE_BITS;
		end else if (bit_cnt_q != 4'd0) begin
			crc_q     <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
			bit_cnt_q <= bit_cnt_q - 4'd1;
		end
	end

	assign crc  = crc_q;
	assign busy = (bit_cnt_q != 4'd0);

endmodule

### design/modbus_read_holding_master.sv
// modbus rtu master for read holding registers: request builder, reply checker, value store
//
// channel  dir  handshake               payload
// req      in   req_valid / req_ready   action, slave_addr, start_reg, reg_count, rx_byte
// rsp      out  rsp_valid / rsp_ready   kind, data, fail_code, last
// cfg      in   apb psel/penable        timeout_ticks at 0x0
//
// start: the request is loaded, then six frame bytes, each output and then run through the
// bit-serial crc, then the two crc bytes, all subject to output stalls; bad count: a fail result;
// received byte: header and body bytes pass through the crc unit; tick: counted while idle
// last reply byte: if header and crc are good, each register value is read out of the store, then done
// one item at a time; req_ready is low while a run of results or the crc is busy
// reset: no clearing pass, the value store is written in each reply before it is read
module modbus_read_holding_master import mbrh_pkg::*; #(
	parameter int unsigned MAX_REGS = MAX_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  slave_addr,
	input  logic [15:0] start_reg,
	input  logic [7:0]  reg_count,
	input  logic [7:0]  rx_byte,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  kind,
	output logic [15:0] data,
	output logic [2:0]  fail_code,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned CNT_W = $clog2(MAX_REGS + 1);
	localparam int unsigned IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
	localparam int unsigned RXI_W = $clog2(2 * MAX_REGS + 5);
	localparam logic [7:0]  MAX_CNT = 8'(MAX_REGS);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_TX_EMIT = 8'b0000_0010,
		S_TX_CRC  = 8'b0000_0100,
		S_RX_CRC  = 8'b0000_1000,
		S_RD_ADDR = 8'b0001_0000,
		S_RD_EMIT = 8'b0010_0000,
		S_FAIL    = 8'b0100_0000,
		S_OK      = 8'b1000_0000
	} state_t;

	state_t            st_q;
	logic              phase_wait_q;
	logic [7:0]        exp_addr_q;
	logic [CNT_W-1:0]  exp_count_q;
	logic [RXI_W-1:0]  rx_index_q;
	logic              hdr_bad_q;
	logic [7:0]        held_q;
	logic [15:0]       tick_q;
	logic [15:0]       timeout_q;
	logic [47:0]       frame_q;
	logic [2:0]        tx_idx_q;
	fail_t             fail_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [15:0]       rd_data_q;
	logic [15:0]       mem_q [MAX_REGS];

	logic              rsp_valid_q;
	kind_t             kind_q;
	logic [15:0]       data_q;
	fail_t             fail_code_q;
	logic              last_q;

	logic              req_fire;
	logic              slot_free;
	logic              rsp_load;
	logic              cfg_wr;
	logic              cnt_bad;
	logic              is_start;
	logic              is_byte;
	logic              is_tick;
	logic [RXI_W-1:0]  body;
	logic [RXI_W-1:0]  rx_off;
	logic              rx_in_body;
	logic [15:0]       tick_next;
	logic              tick_fail;
	logic              hdr_err_now;
	logic [7:0]        tx_byte;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic              mem_re;
	crc_ctrl_t         crc_ctrl;
	logic [15:0]       crc;
	logic              crc_busy;

	mbrh_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.crc    (crc),
		.busy   (crc_busy)
	);

	assign req_ready = (st_q == S_IDLE);
	assign req_fire  = req_valid & req_ready;
	assign slot_free = !rsp_valid_q | rsp_ready;
	assign rsp_load  = slot_free && ((st_q == S_TX_EMIT) || (st_q == S_RD_EMIT)
		|| (st_q == S_FAIL) || (st_q == S_OK));

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_TIMEOUT);
	assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'h0000, timeout_q} : 32'h0000_0000;

	assign is_start = (action == ACT_START);
	assign is_byte  = (action == ACT_BYTE);
	assign is_tick  = (action == ACT_TICK);
	assign cnt_bad  = (reg_count > MAX_CNT);

	assign body       = RXI_W'(3) + RXI_W'({exp_count_q, 1'b0});
	assign rx_off     = rx_index_q - RXI_W'(3);
	assign rx_in_body = (rx_index_q < body);
	assign tick_next  = tick_q + 16'd1;
	assign tick_fail  = (tick_next >= timeout_q) || (tick_next == 16'd0);

	assign hdr_err_now = ((rx_index_q == RXI_W'(0)) && (rx_byte != exp_addr_q))
		|| ((rx_index_q == RXI_W'(1)) && (rx_byte != FUNC_READ))
		|| ((rx_index_q == RXI_W'(2)) && (rx_byte != 8'({exp_count_q, 1'b0})));

	always_comb begin
		unique case (tx_idx_q)
			3'd6:    tx_byte = crc[7:0];
			3'd7:    tx_byte = crc[15:8];
			default: tx_byte = frame_q[47:40];
		endcase
	end

	// the crc restarts on each start with a valid count and again once the request is out, for the reply
	always_comb begin
		crc_ctrl.init = ((st_q == S_TX_EMIT) && slot_free && (tx_idx_q == 3'd7))
			|| (req_fire && is_start && !cnt_bad);
		crc_ctrl.feed = ((st_q == S_TX_EMIT) && slot_free && (tx_idx_q < 3'd6))
			|| (req_fire && is_byte && phase_wait_q && rx_in_body);
		crc_ctrl.din  = (st_q == S_IDLE) ? rx_byte : frame_q[47:40];
	end

	// second byte of each register value goes into the store with the held first byte
	assign mem_we = req_fire && is_byte && phase_wait_q && rx_in_body
		&& (rx_index_q >= RXI_W'(3)) && rx_off[0];
	assign mem_waddr = rx_off[IDX_W:1];
	assign mem_re    = (st_q == S_RD_ADDR) && (rd_idx_q != exp_count_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= {held_q, rx_byte};
		end
		if (mem_re) begin
			rd_data_q <= mem_q[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			phase_wait_q <= 1'b0;
			exp_addr_q   <= 8'h00;
			exp_count_q  <= '0;
			rx_index_q   <= '0;
			hdr_bad_q    <= 1'b0;
			held_q       <= 8'h00;
			tick_q       <= 16'h0000;
			timeout_q    <= TIMEOUT_RST;
			frame_q      <= '0;
			tx_idx_q     <= 3'd0;
			fail_q       <= FAIL_NONE;
			rd_idx_q     <= '0;
			rsp_valid_q  <= 1'b0;
			kind_q       <= KIND_TX;
			data_q       <= 16'h0000;
			fail_code_q  <= FAIL_NONE;
			last_q       <= 1'b0;
		end else begin
			if (cfg_wr) begin
				timeout_q <= pwdata[15:0];
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (st_q)
				S_IDLE: begin
					if (req_fire) begin
						if (is_start) begin
							if (cnt_bad) begin
								phase_wait_q <= 1'b0;
								fail_q       <= FAIL_COUNT;
								st_q         <= S_FAIL;
							end else begin
								frame_q      <= {slave_addr, FUNC_READ, start_reg, 8'h00,
									reg_count};
								exp_addr_q   <= slave_addr;
								exp_count_q  <= reg_count[CNT_W-1:0];
								phase_wait_q <= 1'b1;
								rx_index_q   <= '0;
								hdr_bad_q    <= 1'b0;
								held_q       <= 8'h00;
								tick_q       <= 16'h0000;
								tx_idx_q     <= 3'd0;
								st_q         <= S_TX_EMIT;
							end
						end else if (is_tick && phase_wait_q) begin
							tick_q <= tick_next;
							if (tick_fail) begin
								phase_wait_q <= 1'b0;
								fail_q       <= FAIL_TIMEOUT;
								st_q         <= S_FAIL;
							end
						end else if (is_byte && phase_wait_q) begin
							if (hdr_err_now) begin
								hdr_bad_q <= 1'b1;
							end
							if (rx_in_body) begin
								if ((rx_index_q >= RXI_W'(3)) && !rx_off[0]) begin
									held_q <= rx_byte;
								end
								rx_index_q <= rx_index_q + RXI_W'(1);
								st_q       <= S_RX_CRC;
							end else if (rx_index_q == body) begin
								held_q     <= rx_byte;
								rx_index_q <= rx_index_q + RXI_W'(1);
							end else begin
								// final crc byte closes the reply
								phase_wait_q <= 1'b0;
								rx_index_q   <= '0;
								if (hdr_bad_q) begin
									fail_q <= FAIL_HEADER;
									st_q   <= S_FAIL;
								end else if ({rx_byte, held_q} != crc) begin
									fail_q <= FAIL_CRC;
									st_q   <= S_FAIL;
								end else begin
									rd_idx_q <= '0;
									st_q     <= S_RD_ADDR;
								end
							end
						end
					end
				end
				S_TX_EMIT: begin
					if (slot_free) begin
						kind_q      <= KIND_TX;
						data_q      <= {8'h00, tx_byte};
						fail_code_q <= FAIL_NONE;
						last_q      <= (tx_idx_q == 3'd7);
						if (tx_idx_q < 3'd6) begin
							frame_q  <= {frame_q[39:0], 8'h00};
							tx_idx_q <= tx_idx_q + 3'd1;
							st_q     <= S_TX_CRC;
						end else if (tx_idx_q == 3'd7) begin
							st_q <= S_IDLE;
						end else begin
							tx_idx_q <= tx_idx_q + 3'd1;
						end
					end
				end
				S_TX_CRC: begin
					if (!crc_busy) begin
						st_q <= S_TX_EMIT;
					end
				end
				S_RX_CRC: begin
					if (!crc_busy) begin
						st_q <= S_IDLE;
					end
				end
				S_RD_ADDR: begin
					if (rd_idx_q == exp_count_q) begin
						st_q <= S_OK;
					end else begin
						st_q <= S_RD_EMIT;
					end
				end
				S_RD_EMIT: begin
					if (slot_free) begin
						kind_q      <= KIND_VAL;
						data_q      <= rd_data_q;
						fail_code_q <= FAIL_NONE;
						last_q      <= 1'b0;
						rd_idx_q    <= rd_idx_q + CNT_W'(1);
						st_q        <= S_RD_ADDR;
					end
				end
				S_FAIL: begin
					if (slot_free) begin
						kind_q      <= KIND_FAIL;
						data_q      <= 16'h0000;
						fail_code_q <= fail_q;
						last_q      <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				S_OK: begin
					if (slot_free) begin
						kind_q      <= KIND_OK;
						data_q      <= 16'h0000;
						fail_code_q <= FAIL_NONE;
						last_q      <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign kind      = kind_q;
	assign data      = data_q;
	assign fail_code = fail_code_q;
	assign last      = last_q;

	// a new item never finds the crc unit mid-byte
	a_idle_crc_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !crc_busy)
		else $error("crc busy while taking an item");

	// reply position never runs past the two crc bytes
	a_rx_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_wait_q |-> (rx_index_q <= body + RXI_W'(1)))
		else $error("reply byte index out of range");

	// value readout stays within the register count
	a_rd_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_RD_ADDR) || (st_q == S_RD_EMIT) |-> (rd_idx_q <= exp_count_q))
		else $error("readout index beyond register count");

	// the store is only written while a reply is expected
	a_store_write_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (rx_index_q <= body))
		else $error("value store written outside the reply body");

endmodule
